[sv/b64e_pkg.sv]
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the sextet-to-ASCII mapping of the base64
// stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  // ASCII code of the '=' padding character
  localparam logic [6:0] PAD_CHAR = 7'h3d;

  // Alphabet segment bases
  localparam logic [6:0] ASCII_UPPER_A = 7'h41;
  localparam logic [6:0] ASCII_LOWER_A = 7'h61;
  localparam logic [6:0] ASCII_DIGIT_0 = 7'h30;
  localparam logic [6:0] ASCII_PLUS    = 7'h2b;
  localparam logic [6:0] ASCII_SLASH   = 7'h2f;

  // Index of the final character in a four-character burst
  localparam logic [1:0] LAST_SLOT = 2'd3;

  // One three-byte group handed from the front to the back
  typedef struct packed {
    logic [23:0] group;       // zero-filled group, first byte in the top bits
    logic [1:0]  data_count;  // plain bytes in the group, 1..3
    logic        eom;         // group closes the message
  } group_entry_t;

  // Map six bits onto the standard alphabet
  function automatic logic [6:0] sextet_to_ascii(input logic [5:0] sextet);
    logic [6:0] code;
    code = {1'b0, sextet};
    if (sextet inside {[6'd0 : 6'd25]}) begin
      return ASCII_UPPER_A + code;
    end else if (sextet inside {[6'd26 : 6'd51]}) begin
      return ASCII_LOWER_A + code - 7'd26;
    end else if (sextet inside {[6'd52 : 6'd61]}) begin
      return ASCII_DIGIT_0 + code - 7'd52;
    end else if (sextet == 6'd62) begin
      return ASCII_PLUS;
    end else begin
      return ASCII_SLASH;
    end
  endfunction

endpackage

[sv/b64e_stream_if.sv]
// ----------------------------------------------------------------------------
// b64e_stream_if
// Valid/ready channels of the encoder: plain bytes in, ASCII characters out.
// ----------------------------------------------------------------------------
interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] ascii_char;
  logic       last_char;

  modport source (output valid, output ascii_char, output last_char, input ready);
  modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

[sv/b64e_front.sv]
// ----------------------------------------------------------------------------
// b64e_front
// Gathers plain bytes into three-byte groups and pushes each closed group
// (full, or partial at end of message) into the group queue.
// ----------------------------------------------------------------------------
module b64e_front
  import b64e_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  b64e_byte_if.sink          byte_stream,
  input  logic               queue_full,
  output logic               push,
  output group_entry_t       push_entry
);

  logic [15:0] held_bytes;
  logic [1:0]  group_fill;
  logic        accept;
  logic [1:0]  data_count;

  // Take a byte whenever the queue has room
  assign byte_stream.ready = !queue_full;
  assign accept            = byte_stream.valid && byte_stream.ready;

  // Build the zero-filled group from the held bytes and the new byte
  always_comb begin
    case (group_fill)
      2'd0: begin
        push_entry.group = {byte_stream.data_byte, 16'h0000};
        data_count       = 2'd1;
      end
      2'd1: begin
        push_entry.group = {held_bytes[7:0], byte_stream.data_byte, 8'h00};
        data_count       = 2'd2;
      end
      default: begin
        push_entry.group = {held_bytes, byte_stream.data_byte};
        data_count       = 2'd3;
      end
    endcase
    push_entry.data_count = data_count;
    push_entry.eom        = byte_stream.end_of_message;
  end

  // Close the group when it is full or the message ends
  assign push = accept && ((data_count == 2'd3) || byte_stream.end_of_message);

  // Hold or drop the open group
  always_ff @(posedge clk) begin
    if (rst) begin
      held_bytes <= '0;
      group_fill <= '0;
    end else if (accept) begin
      if (push) begin
        held_bytes <= '0;
        group_fill <= '0;
      end else begin
        held_bytes <= (group_fill == 2'd0) ? {8'h00, byte_stream.data_byte}
                                           : {held_bytes[7:0], byte_stream.data_byte};
        group_fill <= data_count;
      end
    end
  end

endmodule

[sv/b64e_queue.sv]
// ----------------------------------------------------------------------------
// b64e_queue
// Short first-in first-out queue of closed groups between front and back.
// ----------------------------------------------------------------------------
module b64e_queue
  import b64e_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  group_entry_t push_entry,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output group_entry_t head_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  group_entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = entries[rd_ptr];

  // Store pushed groups
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Never overrun or underrun the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("group queue overrun");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("group queue underrun");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("group queue occupancy out of range");

endmodule

[sv/b64e_back.sv]
// ----------------------------------------------------------------------------
// b64e_back
// Expands each queued group into four characters, one per transfer, with
// '=' padding for partial groups and the last flag on the final character.
// ----------------------------------------------------------------------------
module b64e_back
  import b64e_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         head_valid,
  input  group_entry_t head_entry,
  output logic         pop,
  b64e_char_if.source  char_stream
);

  group_entry_t cur;
  logic         active;
  logic [1:0]   slot;
  logic         out_valid;
  logic [6:0]   out_char;
  logic         out_last;

  logic         advance;
  logic         burst_done;
  logic [5:0]   sextet;
  logic [6:0]   char_next;

  // Produce a character whenever the output register is free or drains
  assign advance    = active && (!out_valid || char_stream.ready);
  assign burst_done = advance && (slot == LAST_SLOT);
  assign pop        = head_valid && (!active || burst_done);

  // Select the sextet of the current slot, most significant first
  always_comb begin
    case (slot)
      2'd0:    sextet = cur.group[23:18];
      2'd1:    sextet = cur.group[17:12];
      2'd2:    sextet = cur.group[11:6];
      default: sextet = cur.group[5:0];
    endcase
    char_next = (slot <= cur.data_count) ? sextet_to_ascii(sextet) : PAD_CHAR;
  end

  // Load the next group and step through its slots
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      slot   <= '0;
    end else begin
      if (pop) begin
        active <= 1'b1;
        slot   <= '0;
      end else if (burst_done) begin
        active <= 1'b0;
        slot   <= '0;
      end else if (advance) begin
        slot <= slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head_entry;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (char_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char <= char_next;
      out_last <= cur.eom && (slot == LAST_SLOT);
    end
  end

  assign char_stream.valid      = out_valid;
  assign char_stream.ascii_char = out_char;
  assign char_stream.last_char  = out_last;

  // A loaded group always starts at its first slot
  a_load_slot0: assert property (@(posedge clk) disable iff (rst)
    pop |=> active && (slot == 2'd0))
    else $error("group loaded at a nonzero slot");

  // Padding only after the data characters of a partial group
  a_pad_only_partial: assert property (@(posedge clk) disable iff (rst)
    (advance && (cur.data_count == 2'd3)) |-> (char_next != PAD_CHAR))
    else $error("padding emitted for a full group");

endmodule

[sv/base64_stream_encoder.sv]
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Base64 encoder, standard alphabet: plain bytes in, ASCII characters out.
//
//   channel      role   payload                        end of message
//   byte_stream  in     data_byte[7:0]                 end_of_message
//   char_stream  out    ascii_char[6:0]                last_char
//
// The front accepts one byte per cycle while the group queue has room; a
// byte that closes a group is pushed into the queue in the cycle it is taken.
// The back emits one character per cycle while the output is ready, four per
// group, so the output port paces a steady stream: four characters per three
// input bytes. Each group passes the queue, cur and the output register.
// Reset (rst, synchronous) empties the open group, the queue and the output.
// Either side may stall; the queue of QUEUE_DEPTH groups decouples them.
// ----------------------------------------------------------------------------
module base64_stream_encoder
  import b64e_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  b64e_byte_if.sink   byte_stream,
  b64e_char_if.source char_stream
);

  logic         queue_full;
  logic         push;
  group_entry_t push_entry;
  logic         pop;
  logic         head_valid;
  group_entry_t head_entry;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_stream(byte_stream),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  b64e_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (queue_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_entry(head_entry)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .char_stream(char_stream)
  );

endmodule

[bench/base64_stream_encoder_test.sv]
// ----------------------------------------------------------------------------
// base64_stream_encoder_test
// Self-checking bench for the base64 stream encoder. After reset, a directed
// table covers one-, two- and three-byte groups with all-zero and all-one bytes,
// groups that close with and without end of message, and short text samples.
// Random messages of random length follow. Every character transfer is
// compared with a scoreboard filled by an in-bench encoder or, for typed rows,
// by the table's known answers. Both handshakes stall at random, and the
// output side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module base64_stream_encoder_test;
  import b64e_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;

  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [6:0] ascii_char;
    logic       last_char;
  } char_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        end_of_message;
    logic        typed;   // burst text below is the known answer
    logic [31:0] text;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  b64e_byte_if byte_if ();
  b64e_char_if char_if ();

  base64_stream_encoder uut (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_if),
    .char_stream (char_if)
  );

  always #2 clk = ~clk;

  // In-bench encoder state
  logic [15:0] held_bytes = '0;
  logic [1:0]  group_fill = '0;

  char_t     expected_chars[$];
  int        fail_count = 0;
  int        idle_phase = 0;
  stim_row_t directed_rows [0:23];

  // Map six bits onto the alphabet
  function automatic logic [6:0] base64_symbol(input logic [5:0] sextet);
    logic [7:0] code;
    code = B64_ALPHABET[8*(63 - sextet) +: 8];
    return code[6:0];
  endfunction

  // Encode one byte; burst_len is 4 when a group closes, else 0
  task automatic encode_byte(input logic [7:0] b, input logic eom,
                             output char_t [0:3] burst, output int burst_len);
    logic [23:0] group_word;
    logic [1:0]  fill;
    int          data_chars;
    burst = '0;
    fill = (group_fill > 2'd2) ? 2'd2 : group_fill;
    case (fill)
      2'd0:    group_word = {b, 16'h0000};
      2'd1:    group_word = {held_bytes[7:0], b, 8'h00};
      default: group_word = {held_bytes, b};
    endcase
    burst_len = 0;
    if (fill < 2'd2 && !eom) begin
      held_bytes = (fill == 2'd0) ? {8'h00, b} : {held_bytes[7:0], b};
      group_fill = fill + 2'd1;
    end else begin
      data_chars = fill + 2;
      for (int k = 0; k < 4; k++) begin
        burst[k].ascii_char = (k < data_chars) ? base64_symbol(group_word[18 - 6*k +: 6])
                                               : PAD_CHAR;
        burst[k].last_char = (k == 3) && eom;
      end
      burst_len = 4;
      held_bytes = '0;
      group_fill = '0;
    end
  endtask

  // Offer one byte after a random gap and wait for its transfer
  task automatic send_byte(input logic [7:0] b, input logic eom,
                           input logic typed, input logic [31:0] text);
    char_t [0:3] burst;
    int          burst_len;
    int          idle_pct;
    idle_pct = (idle_phase == 0) ? 31 : (idle_phase == 1) ? 85 : 0;
    while ($urandom_range(99) < idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk);
    end
    byte_if.valid          <= 1'b1;
    byte_if.data_byte      <= b;
    byte_if.end_of_message <= eom;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    encode_byte(b, eom, burst, burst_len);
    for (int k = 0; k < burst_len; k++) begin
      if (typed) begin
        burst[k].ascii_char = text[8*(3 - k) +: 7];
        burst[k].last_char  = (k == 3) && eom;
      end
      expected_chars.push_back(burst[k]);
    end
  endtask

  // Compare one character transfer with the oldest expectation
  task automatic check_char(input logic [6:0] got_char, input logic got_last);
    char_t want;
    if (expected_chars.size() == 0) begin
      $display("%0t: unexpected char: expected none, actual %h last %b",
               $time, got_char, got_last);
      fail_count++;
    end else begin
      want = expected_chars.pop_front();
      if (got_char !== want.ascii_char) begin
        $display("%0t: ascii_char mismatch: expected %h, actual %h",
                 $time, want.ascii_char, got_char);
        fail_count++;
      end
      if (got_last !== want.last_char) begin
        $display("%0t: last_char mismatch: expected %b, actual %b",
                 $time, want.last_char, got_last);
        fail_count++;
      end
    end
  endtask

  // Stimulus: reset, directed table, random messages, drain
  initial begin
    int         sent;
    int         msg_len;
    logic [7:0] b;
    byte_if.valid          <= 1'b0;
    byte_if.data_byte      <= 8'h00;
    byte_if.end_of_message <= 1'b0;
    directed_rows = '{
      '{8'h00, 1'b1, 1'b1, "AA=="},
      '{8'hff, 1'b1, 1'b1, "/w=="},
      '{8'h00, 1'b0, 1'b0, 32'h0}, '{8'h00, 1'b1, 1'b1, "AAA="},
      '{8'hff, 1'b0, 1'b0, 32'h0}, '{8'hff, 1'b1, 1'b1, "//8="},
      '{8'h00, 1'b0, 1'b0, 32'h0}, '{8'h00, 1'b0, 1'b0, 32'h0},
      '{8'h00, 1'b1, 1'b1, "AAAA"},
      '{8'hff, 1'b0, 1'b0, 32'h0}, '{8'hff, 1'b0, 1'b0, 32'h0},
      '{8'hff, 1'b1, 1'b1, "////"},
      // full group without end of message, then more of the same message
      '{8'hff, 1'b0, 1'b0, 32'h0}, '{8'hff, 1'b0, 1'b0, 32'h0},
      '{8'hff, 1'b0, 1'b1, "////"},
      '{8'h4d, 1'b0, 1'b0, 32'h0}, '{8'h61, 1'b0, 1'b0, 32'h0},
      '{8'h6e, 1'b1, 1'b1, "TWFu"},
      '{8'h4d, 1'b0, 1'b0, 32'h0}, '{8'h61, 1'b1, 1'b1, "TWE="},
      '{8'h4d, 1'b1, 1'b1, "TQ=="},
      '{8'h80, 1'b0, 1'b0, 32'h0}, '{8'h01, 1'b0, 1'b0, 32'h0},
      '{8'h7e, 1'b1, 1'b0, 32'h0}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].data_byte, directed_rows[i].end_of_message,
                directed_rows[i].typed, directed_rows[i].text);
    end

    // Random messages, mostly short; idling pattern advances by thirds
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      msg_len = ($urandom_range(9) < 8) ? $urandom_range(1, 7) : $urandom_range(8, 24);
      for (int i = 0; i < msg_len; i++) begin
        idle_phase = (sent * 3) / RANDOM_ITEMS;
        case ($urandom_range(7))
          0:       b = 8'h00;
          1:       b = 8'hff;
          default: b = 8'($urandom);
        endcase
        send_byte(b, i == msg_len - 1, 1'b0, 32'h0);
        sent++;
      end
    end
    byte_if.valid <= 1'b0;

    // Drain the scoreboard, then watch for stray characters
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver: random ready, one long hold-off once the no-idle phase starts
  initial begin
    int hold_left;
    bit hold_done;
    int idle_pct;
    hold_left = 0;
    hold_done = 1'b0;
    char_if.ready <= 1'b0;
    forever begin
      if (idle_phase == 2 && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      idle_pct = (idle_phase == 0) ? 85 : (idle_phase == 1) ? 31 : 0;
      if (rst || hold_left > 0) begin
        char_if.ready <= 1'b0;
        if (hold_left > 0) hold_left--;
      end else begin
        char_if.ready <= ($urandom_range(99) >= idle_pct);
      end
      @(posedge clk);
      if (!rst && char_if.valid && char_if.ready) begin
        check_char(char_if.ascii_char, char_if.last_char);
      end
    end
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
sv/b64e_pkg.sv
sv/b64e_stream_if.sv
sv/b64e_front.sv
sv/b64e_queue.sv
sv/b64e_back.sv
sv/base64_stream_encoder.sv
bench/base64_stream_encoder_test.sv
